FILE: rtl/deqi_pkg.sv
package deqi_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DEPTH_MAX = 1024;
    localparam int IDX_W     = $clog2(DEPTH_MAX + 1);
    localparam int WORD_W    = 32;
    localparam int CMD_W     = 3;
    localparam int POS_W     = 5;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDER = 2'd2;

    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_INS   = 2'd1;
    localparam logic [1:0] CELL_SHIFT = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] data_in;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data_out;
        logic [CNT_W-1:0]         count_out;
    } rsp_t;

    typedef struct packed {
        logic [1:0]               op;
        logic [IDX_W-1:0]         ins_idx;
        logic [IDX_W-1:0]         sel_idx;
        logic signed [WORD_W-1:0] word;
    } cell_ctrl_t;

endpackage

FILE: rtl/double_ended_queue_with_insert_top.sv
// channel   signals                     handshake
// -------   -------------------------   ----------------------------------
// command   request (cmd, data_in,      word taken at clk edge with start
//           position)                   high and busy low
// result    result (status, data_out,   done high for one cycle; taken at
//           count_out)                  the edge ending that cycle
//
// One command per cycle: the row of cells shifts or inserts in parallel in
// the accepting cycle, and the result appears the next cycle with done.
// busy stays low, so back-to-back starts are all taken.
// rst_n clears the count and done; cell contents are undefined until written.
// The receiver cannot stall; a result not taken in its cycle is gone.
module double_ended_queue_with_insert_top #(
    parameter int DEPTH = deqi_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  deqi_pkg::req_t request,
    output logic           done,
    output deqi_pkg::rsp_t result
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > deqi_pkg::POS_W) ? CW : deqi_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CW-1:0]                      count_reg;
    logic [CW-1:0]                      count_next;
    logic                               done_reg;
    deqi_pkg::rsp_t                     rsp_reg;
    deqi_pkg::rsp_t                     rsp_next;
    deqi_pkg::cell_ctrl_t               ctrl;
    logic                               accept;
    logic                               full;
    logic                               empty;
    logic signed [deqi_pkg::WORD_W-1:0] cell_q  [DEPTH];
    logic signed [deqi_pkg::WORD_W-1:0] cell_rd [DEPTH];
    logic signed [deqi_pkg::WORD_W-1:0] back_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == DEPTH_C);
    assign empty  = (count_reg == '0);

    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | cell_rd[i];
        end
    end

    always_comb
    begin
        ctrl.op       = deqi_pkg::CELL_HOLD;
        ctrl.ins_idx  = '0;
        ctrl.sel_idx  = deqi_pkg::IDX_W'(count_reg - CW'(1));
        ctrl.word     = request.data_in;
        count_next    = count_reg;
        rsp_next.status   = deqi_pkg::ST_OK;
        rsp_next.data_out = '0;
        unique case (request.cmd) inside
            deqi_pkg::CMD_PUSH_FRONT, deqi_pkg::CMD_PUSH_BACK, deqi_pkg::CMD_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = deqi_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.op    = deqi_pkg::CELL_INS;
                    count_next = count_reg + CW'(1);
                    if (request.cmd == deqi_pkg::CMD_PUSH_BACK)
                    begin
                        ctrl.ins_idx = deqi_pkg::IDX_W'(count_reg);
                    end
                    else if (request.cmd == deqi_pkg::CMD_INSERT &&
                             request.position != '0)
                    begin
                        if (CMPW'(request.position) >= CMPW'(count_reg))
                        begin
                            ctrl.ins_idx = deqi_pkg::IDX_W'(count_reg);
                        end
                        else
                        begin
                            ctrl.ins_idx = deqi_pkg::IDX_W'(request.position);
                        end
                    end
                end
            end
            deqi_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    rsp_next.status = deqi_pkg::ST_UNDER;
                end
                else
                begin
                    ctrl.op           = deqi_pkg::CELL_SHIFT;
                    rsp_next.data_out = cell_q[0];
                    count_next        = count_reg - CW'(1);
                end
            end
            deqi_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    rsp_next.status = deqi_pkg::ST_UNDER;
                end
                else
                begin
                    rsp_next.data_out = back_word;
                    count_next        = count_reg - CW'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.count_out = deqi_pkg::CNT_W'(count_next);
        if (!accept)
        begin
            ctrl.op = deqi_pkg::CELL_HOLD;
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [deqi_pkg::WORD_W-1:0] left_w;
        logic signed [deqi_pkg::WORD_W-1:0] right_w;
        if (g == 0)
        begin : g_first
            assign left_w = request.data_in;
        end
        else
        begin : g_mid_l
            assign left_w = cell_q[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = cell_q[g];
        end
        else
        begin : g_mid_r
            assign right_w = cell_q[g+1];
        end
        deqi_cell #(
            .IDX (g)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .left  (left_w),
            .right (right_w),
            .q     (cell_q[g]),
            .rd    (cell_rd[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("count above depth");

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(start))
        else $error("result without command");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.cmd == deqi_pkg::CMD_PUSH_BACK && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow count");

    a_underflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.status == deqi_pkg::ST_UNDER)
        |-> (rsp_reg.data_out == '0 && $stable(count_reg)))
        else $error("underflow result wrong");

endmodule

FILE: rtl/deqi_cell.sv
module deqi_cell #(
    parameter int IDX = 0
) (
    input  logic                                 clk,
    input  deqi_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [deqi_pkg::WORD_W-1:0]   left,
    input  logic signed [deqi_pkg::WORD_W-1:0]   right,
    output logic signed [deqi_pkg::WORD_W-1:0]   q,
    output logic signed [deqi_pkg::WORD_W-1:0]   rd
);

    localparam logic [deqi_pkg::IDX_W-1:0] MY_IDX = deqi_pkg::IDX_W'(IDX);

    logic signed [deqi_pkg::WORD_W-1:0] data_reg;
    logic signed [deqi_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            deqi_pkg::CELL_INS:
            begin
                if (MY_IDX == ctrl.ins_idx)
                begin
                    data_next = ctrl.word;
                end
                else if (MY_IDX > ctrl.ins_idx)
                begin
                    data_next = left;
                end
            end
            deqi_pkg::CELL_SHIFT:
            begin
                data_next = right;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q  = data_reg;
    assign rd = (MY_IDX == ctrl.sel_idx) ? data_reg : '0;

endmodule
